FILE: rtl/core/mau_pkg.sv
// ============================================================================
// Matrix arithmetic unit package
// Sizes, operation codes and the command and status types that pass between
// the controller and the datapath.
// ============================================================================
`default_nettype none

package mau_pkg;

   // Matrix size and derived widths.
   localparam int DIM    = 4;
   localparam int CELLS  = DIM * DIM;
   localparam int DATA_W = 32;
   localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int RC_W   = (DIM > 1) ? $clog2(DIM) : 1;

   // Operation register codes.
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Source that loads the result register.
   typedef enum logic [1:0] {
      OUT_HOLD   = 2'd0,
      OUT_ADDSUB = 2'd1,
      OUT_ACC    = 2'd2,
      OUT_DIV    = 2'd3
   } out_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              mem_wr;
      logic [IDX_W-1:0]  wr_addr;
      logic [IDX_W-1:0]  rd_a_addr;
      logic [IDX_W-1:0]  rd_b_addr;
      logic              sub;
      logic              mul_en;
      logic              acc_en;
      logic              acc_first;
      logic              div_start;
      out_sel_type       out_sel;
      logic              out_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/mau_if.sv
// ============================================================================
// Matrix arithmetic unit channels
// Valid/ready channels for element pairs in and result elements out.
// ============================================================================
`default_nettype none

// Element pair channel: one beat carries one element of A and one of B.
interface mau_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mau_pkg::DATA_W-1:0]    a_value;
   logic signed [mau_pkg::DATA_W-1:0]    b_value;

   modport source (output valid, output a_value, output b_value, input ready);
   modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

// Result channel: one beat carries one element of the result matrix.
interface mau_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mau_pkg::DATA_W-1:0]    value;
   logic                                 last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mau_divider.sv
// ============================================================================
// Matrix arithmetic unit divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating
// toward zero. A zero divisor and the single overflow case finish at once.
// ============================================================================
`default_nettype none

module mau_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mau_pkg::DATA_W-1:0]    dividend,
   input  wire logic [mau_pkg::DATA_W-1:0]    divisor,
   output logic                               done,
   output logic [mau_pkg::DATA_W-1:0]         quotient
);

   localparam int W     = mau_pkg::DATA_W;
   localparam int CNT_W = $clog2(W);

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [W-1:0]     mag_a;
   logic [W-1:0]     mag_b;
   logic [W:0]       shifted;
   logic [W:0]       trial;

   // Operand magnitudes; the most negative value maps to itself unsigned.
   assign mag_a = dividend[W-1] ? (~dividend + W'(1)) : dividend;
   assign mag_b = divisor[W-1]  ? (~divisor + W'(1))  : divisor;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               den_in = mag_b;
               rem_in = '0;
               cnt_in = '0;
               if (divisor == '0) begin
                  quo_in   = '0;
                  neg_in   = 1'b0;
                  state_in = S_DONE;
               end else if (dividend == {1'b1, {(W-1){1'b0}}} && divisor == '1) begin
                  quo_in   = {1'b1, {(W-1){1'b0}}};
                  neg_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  quo_in   = mag_a;
                  neg_in   = dividend[W-1] ^ divisor[W-1];
                  state_in = S_BUSY;
               end
            end
         end
         S_BUSY: begin
            if (!trial[W]) begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(W-1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Result with the sign applied, valid while done is high.
   assign done     = (state_ff == S_DONE);
   assign quotient = neg_ff ? (~quo_ff + W'(1)) : quo_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mau_datapath.sv
// ============================================================================
// Matrix arithmetic unit datapath
// Operand memories, adder, multiply-accumulate, divider and result register.
// ============================================================================
`default_nettype none

module mau_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mau_pkg::cmd_type                     cmd,
   input  wire logic signed [mau_pkg::DATA_W-1:0]    wr_a,
   input  wire logic signed [mau_pkg::DATA_W-1:0]    wr_b,
   output mau_pkg::status_type                       status,
   output logic signed [mau_pkg::DATA_W-1:0]         out_value,
   output logic                                      out_last
);

   localparam int W = mau_pkg::DATA_W;

   logic [W-1:0] mem_a_ff [mau_pkg::CELLS];
   logic [W-1:0] mem_b_ff [mau_pkg::CELLS];
   logic [W-1:0] rd_a_ff;
   logic [W-1:0] rd_b_ff;
   logic [W-1:0] prod_ff;
   logic [W-1:0] prod_in;
   logic [W-1:0] acc_ff;
   logic [W-1:0] acc_in;
   logic [W-1:0] addsub;
   logic [W-1:0] out_value_ff;
   logic         out_last_ff;
   logic         div_done;
   logic [W-1:0] div_quotient;

   // Operand memories: written during load, read with registered data.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem_a_ff[cmd.wr_addr] <= wr_a;
         mem_b_ff[cmd.wr_addr] <= wr_b;
      end
      rd_a_ff <= mem_a_ff[cmd.rd_a_addr];
      rd_b_ff <= mem_b_ff[cmd.rd_b_addr];
   end

   // Elementwise sum or difference, wrapping modulo 2^32.
   assign addsub = cmd.sub ? (rd_a_ff - rd_b_ff) : (rd_a_ff + rd_b_ff);

   // Low word of the product; the low bits are the same signed or unsigned.
   assign prod_in = rd_a_ff * rd_b_ff;

   // The first term of a dot product starts the sum afresh.
   assign acc_in = (cmd.acc_first ? '0 : acc_ff) + prod_ff;

   // Product and accumulator registers.
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // Shared divider for the elementwise quotient.
   mau_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_a_ff),
      .divisor  (rd_b_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Result register, loaded from the unit that finished.
   always_ff @(posedge clock) begin
      case (cmd.out_sel)
         mau_pkg::OUT_ADDSUB: out_value_ff <= addsub;
         mau_pkg::OUT_ACC:    out_value_ff <= acc_in;
         mau_pkg::OUT_DIV:    out_value_ff <= div_quotient;
         default:             out_value_ff <= out_value_ff;
      endcase
      if (cmd.out_sel != mau_pkg::OUT_HOLD) begin
         out_last_ff <= cmd.out_last;
      end
   end

   assign status.div_done = div_done;
   assign out_value       = out_value_ff;
   assign out_last        = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mau_ctrl.sv
// ============================================================================
// Matrix arithmetic unit controller
// Counts loaded pairs, walks the result matrix and sequences the datapath.
// ============================================================================
`default_nettype none

module mau_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_wdata,
   input  wire mau_pkg::status_type   status,
   output mau_pkg::cmd_type           cmd
);

   localparam int IDX_W = mau_pkg::IDX_W;
   localparam int RC_W  = mau_pkg::RC_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_EXEC,
      ST_MACC,
      ST_DIVW,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] load_cnt_ff, load_cnt_in;
   logic [RC_W-1:0]  row_ff, row_in;
   logic [RC_W-1:0]  col_ff, col_in;
   logic [RC_W-1:0]  k_ff, k_in;
   mau_pkg::op_type  op_ff, op_in;
   mau_pkg::op_type  op_run_ff, op_run_in;

   logic             in_fire;
   logic             out_fire;
   logic             load_done;
   logic             k_last;
   logic             elem_last;
   logic [RC_W-1:0]  a_col;
   logic [RC_W-1:0]  b_row;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign in_fire   = req_ready && req_valid;
   assign out_fire  = rsp_valid && rsp_ready;
   assign load_done = (load_cnt_ff == IDX_W'(mau_pkg::CELLS - 1));
   assign k_last    = (k_ff == RC_W'(mau_pkg::DIM - 1));
   assign elem_last = (row_ff == RC_W'(mau_pkg::DIM - 1)) &&
                      (col_ff == RC_W'(mau_pkg::DIM - 1));

   // Read addresses: a matrix product walks row r of A and column c of B.
   assign a_col = (op_run_ff == mau_pkg::OP_MUL) ? k_ff : col_ff;
   assign b_row = (op_run_ff == mau_pkg::OP_MUL) ? k_ff : row_ff;

   // Datapath commands decoded from the state.
   always_comb begin
      cmd.mem_wr    = in_fire;
      cmd.wr_addr   = load_cnt_ff;
      cmd.rd_a_addr = IDX_W'(row_ff) * IDX_W'(mau_pkg::DIM) + IDX_W'(a_col);
      cmd.rd_b_addr = IDX_W'(b_row) * IDX_W'(mau_pkg::DIM) + IDX_W'(col_ff);
      cmd.sub       = (op_run_ff == mau_pkg::OP_SUB);
      cmd.mul_en    = (state_ff == ST_EXEC) && (op_run_ff == mau_pkg::OP_MUL);
      cmd.acc_en    = (state_ff == ST_MACC);
      cmd.acc_first = (k_ff == '0);
      cmd.div_start = (state_ff == ST_EXEC) && (op_run_ff == mau_pkg::OP_DIV);
      cmd.out_last  = elem_last;
      cmd.out_sel   = mau_pkg::OUT_HOLD;
      if ((state_ff == ST_EXEC) &&
          (op_run_ff == mau_pkg::OP_ADD || op_run_ff == mau_pkg::OP_SUB)) begin
         cmd.out_sel = mau_pkg::OUT_ADDSUB;
      end else if ((state_ff == ST_MACC) && k_last) begin
         cmd.out_sel = mau_pkg::OUT_ACC;
      end else if ((state_ff == ST_DIVW) && status.div_done) begin
         cmd.out_sel = mau_pkg::OUT_DIV;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      op_in       = op_ff;
      op_run_in   = op_run_ff;
      if (csr_we) begin
         op_in = mau_pkg::op_type'(csr_wdata);
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (in_fire) begin
               if (load_done) begin
                  load_cnt_in = '0;
                  op_run_in   = op_ff;
                  row_in      = '0;
                  col_in      = '0;
                  k_in        = '0;
                  state_in    = ST_READ;
               end else begin
                  load_cnt_in = load_cnt_ff + IDX_W'(1);
               end
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (op_run_ff)
               mau_pkg::OP_MUL: state_in = ST_MACC;
               mau_pkg::OP_DIV: state_in = ST_DIVW;
               default:         state_in = ST_EMIT;
            endcase
         end
         ST_MACC: begin
            if (k_last) begin
               k_in     = '0;
               state_in = ST_EMIT;
            end else begin
               k_in     = k_ff + RC_W'(1);
               state_in = ST_READ;
            end
         end
         ST_DIVW: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_fire) begin
               if (elem_last) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_READ;
                  if (col_ff == RC_W'(mau_pkg::DIM - 1)) begin
                     col_in = '0;
                     row_in = row_ff + RC_W'(1);
                  end else begin
                     col_in = col_ff + RC_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State, counters and the operation register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         k_ff        <= '0;
         op_ff       <= mau_pkg::OP_ADD;
         op_run_ff   <= mau_pkg::OP_ADD;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         k_ff        <= k_in;
         op_ff       <= op_in;
         op_run_ff   <= op_run_in;
      end
   end

   // The beat that completes the matrices closes the input channel.
   a_load_closes: assert property (@(posedge clock) disable iff (reset)
      (in_fire && load_done) |=> !req_ready)
      else $error("input still open after the final load beat");

   // Delivering the last result reopens the input channel.
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (out_fire && elem_last) |=> (req_ready && load_cnt_ff == '0))
      else $error("input not reopened after the last result beat");

   // The divider is only started for an elementwise quotient.
   a_div_op: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (op_run_ff == mau_pkg::OP_DIV))
      else $error("divider started for another operation");

   // A dot product is handed to the result register only after its last term.
   a_acc_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sel == mau_pkg::OUT_ACC) |-> (k_last && op_run_ff == mau_pkg::OP_MUL))
      else $error("accumulator taken before the last term");

endmodule

`default_nettype wire

FILE: rtl/core/matrix_arithmetic_unit.sv
// ============================================================================
// Matrix arithmetic unit
// Loads DIM*DIM element pairs of A and B, then returns A+B, A-B, A*B or the
// elementwise quotient A/B, row-major, with the last element marked.
// ============================================================================
//
//   Channel   Direction   Payload                  Handshake
//   req_ch    in          a_value, b_value         valid / ready
//   rsp_ch    out         value, last              valid / ready
//   csr       in          csr_wdata (operation)    csr_we
//
// Loading writes each accepted element pair through the single memory write port.
// Each result element is then read, executed and emitted; the matrix product
// repeats read, execute and one multiply-accumulate per term, and the quotient
// waits on the divider (one bit per cycle; zero divisor or overflow skip the loop).
// Input is held off from the final load beat until the last result is taken;
// a stalled result simply waits in the output register.
// Reset is synchronous and clears the controller and the operation register.
`default_nettype none

module matrix_arithmetic_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   mau_req_if.sink      req_ch,
   mau_rsp_if.source    rsp_ch,
   input  wire logic    csr_we,
   input  wire logic [1:0] csr_wdata
);

   mau_pkg::cmd_type    cmd;
   mau_pkg::status_type status;

   // Sequencer.
   mau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   mau_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_a      (req_ch.a_value),
      .wr_b      (req_ch.b_value),
      .status    (status),
      .out_value (rsp_ch.value),
      .out_last  (rsp_ch.last)
   );

endmodule

`default_nettype wire
